@@ sv/hpid_pkg.sv @@
// Shared types, widths, constants and the command clamp for the heading PID block
`timescale 1ns / 1ps

package hpid_pkg;

    // field and datapath widths
    localparam int HEAD_W = 17;   // heading and wrapped error
    localparam int DIFF_W = 18;   // raw difference of two headings
    localparam int WRAP_W = 20;   // headroom for the wrap adds
    localparam int GAIN_W = 32;   // Q16.16 gains, limits, integrator, command
    localparam int PROD_W = 50;   // gain times error or measurement change
    localparam int SUM_W  = 52;   // sum of all terms, exact
    localparam int CFG_IDX_W = 3;

    typedef logic signed [HEAD_W-1:0] heading_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [WRAP_W-1:0] wrap_t;
    typedef logic signed [GAIN_W-1:0] q16_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // register indexes of the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP   = 3'd0,
        CFG_KI   = 3'd1,
        CFG_KD   = 3'd2,
        CFG_LOW  = 3'd3,
        CFG_HIGH = 3'd4
    } cfg_idx_t;

    // angle constants in centidegrees
    localparam wrap_t HALF_TURN = 20'sd18000;
    localparam wrap_t FULL_TURN = 20'sd36000;
    localparam wrap_t TWO_TURNS = 20'sd72000;

    // high tested first; reversed limits give high above it, low at or below it
    function automatic q16_t clamp_cmd(input sum_t v, input q16_t lo, input q16_t hi);
        sum_t lo_x;
        sum_t hi_x;
        lo_x = SUM_W'(lo);
        hi_x = SUM_W'(hi);
        if (v > hi_x)
            return hi;
        else if (v < lo_x)
            return lo;
        else
            return v[GAIN_W-1:0];
    endfunction

endpackage

@@ sv/hpid_err_wrap.sv @@
// Heading error wrap into one turn, followed by saturation to one full turn
`timescale 1ns / 1ps

module hpid_err_wrap (
    input  hpid_pkg::diff_t    diff,
    output hpid_pkg::heading_t err
);

    hpid_pkg::wrap_t d0;
    hpid_pkg::wrap_t d1;
    hpid_pkg::wrap_t d2;
    hpid_pkg::wrap_t d3;

    assign d0 = hpid_pkg::WRAP_W'(diff);

    // add a turn beyond half a turn, take two off beyond a full turn, then saturate
    always_comb
    begin
        if (d0 > hpid_pkg::HALF_TURN || d0 < -hpid_pkg::HALF_TURN)
            d1 = d0 + hpid_pkg::FULL_TURN;
        else
            d1 = d0;

        if (d1 > hpid_pkg::FULL_TURN || d1 < -hpid_pkg::FULL_TURN)
            d2 = d1 - hpid_pkg::TWO_TURNS;
        else
            d2 = d1;

        if (d2 > hpid_pkg::FULL_TURN)
            d3 = hpid_pkg::FULL_TURN;
        else if (d2 < -hpid_pkg::FULL_TURN)
            d3 = -hpid_pkg::FULL_TURN;
        else
            d3 = d2;
    end

    assign err = d3[hpid_pkg::HEAD_W-1:0];

endmodule

@@ sv/heading_pid_with_angle_wrap.sv @@
// Heading PID controller with angle wrap: top level, five-stage pipeline
`timescale 1ns / 1ps

// Takes one sample (target and measured heading, centidegrees) per transaction and
// returns one result: the saturated Q16.16 drive command and the wrapped heading error.
// The pipeline has five register stages (difference, wrap, multiply, integrate, output);
// a result is offered from the output stage and held there until it is taken. A new
// sample can be taken every cycle unless a stalled output has filled every stage, and the
// integrator add and clamp closes its loop within one stage.
// Each stage holds its item until the next stage frees, so bubbles collapse and a sample
// is still taken while a finished result waits at the output, if an earlier stage is empty.
// Gains and limits are written through the configuration channel, by the user only while
// no sample is in flight, which the block does not enforce; unlisted indexes are ignored.
module heading_pid_with_angle_wrap (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [16:0] target_heading, [33:17] measured_heading
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [31:0] drive_command, [48:32] heading_error
);

    // configuration registers
    hpid_pkg::q16_t kp_reg;
    hpid_pkg::q16_t ki_reg;
    hpid_pkg::q16_t kd_reg;
    hpid_pkg::q16_t lo_reg;
    hpid_pkg::q16_t hi_reg;

    // controller state
    hpid_pkg::q16_t     integ_reg;
    hpid_pkg::heading_t prev_meas_reg;

    // stage valids and handshakes
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic ld1, ld2, ld3, ld4, ld5, ld_out;

    // stage payloads
    hpid_pkg::diff_t    diff1_reg;
    hpid_pkg::diff_t    deriv1_reg;
    hpid_pkg::heading_t err2_reg;
    hpid_pkg::diff_t    deriv2_reg;
    hpid_pkg::heading_t err3_reg;
    hpid_pkg::prod_t    p_prod3_reg;
    hpid_pkg::prod_t    i_prod3_reg;
    hpid_pkg::prod_t    d_prod3_reg;
    hpid_pkg::heading_t err4_reg;
    hpid_pkg::sum_t     pd_sum4_reg;
    hpid_pkg::heading_t err5_reg;
    hpid_pkg::q16_t     cmd5_reg;

    hpid_pkg::heading_t tgt_in;
    hpid_pkg::heading_t meas_in;
    hpid_pkg::heading_t err_wrapped;
    hpid_pkg::sum_t     integ_sum;
    hpid_pkg::sum_t     cmd_sum;

    assign tgt_in  = s_tdata[16:0];
    assign meas_in = s_tdata[33:17];

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (hpid_pkg::cfg_idx_t'(cfg_index))
                hpid_pkg::CFG_KP:   kp_reg <= cfg_data;
                hpid_pkg::CFG_KI:   ki_reg <= cfg_data;
                hpid_pkg::CFG_KD:   kd_reg <= cfg_data;
                hpid_pkg::CFG_LOW:  lo_reg <= cfg_data;
                hpid_pkg::CFG_HIGH: hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ready chain: a stage loads when empty or when its item moves on
    assign rdy5   = !v5_reg || m_tready;
    assign rdy4   = !v4_reg || rdy5;
    assign rdy3   = !v3_reg || rdy4;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign ld1    = s_tvalid && rdy1;
    assign ld2    = v1_reg && rdy2;
    assign ld3    = v2_reg && rdy3;
    assign ld4    = v3_reg && rdy4;
    assign ld5    = v4_reg && rdy5;
    assign ld_out = v5_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ld1 || (v1_reg && !ld2);
            v2_reg <= ld2 || (v2_reg && !ld3);
            v3_reg <= ld3 || (v3_reg && !ld4);
            v4_reg <= ld4 || (v4_reg && !ld5);
            v5_reg <= ld5 || (v5_reg && !ld_out);
        end
    end

    // previous measurement follows each taken sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_meas_reg <= '0;
        else if (ld1)
            prev_meas_reg <= meas_in;
    end

    // stage 1: raw error and measurement change
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            diff1_reg  <= hpid_pkg::DIFF_W'(tgt_in) - hpid_pkg::DIFF_W'(meas_in);
            deriv1_reg <= hpid_pkg::DIFF_W'(meas_in) - hpid_pkg::DIFF_W'(prev_meas_reg);
        end
    end

    // stage 2: wrapped and saturated error
    hpid_err_wrap u_err_wrap (
        .diff (diff1_reg),
        .err  (err_wrapped)
    );

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            err2_reg   <= err_wrapped;
            deriv2_reg <= deriv1_reg;
        end
    end

    // stage 3: the three gain products
    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            err3_reg    <= err2_reg;
            p_prod3_reg <= hpid_pkg::PROD_W'(kp_reg) * hpid_pkg::PROD_W'(err2_reg);
            i_prod3_reg <= hpid_pkg::PROD_W'(ki_reg) * hpid_pkg::PROD_W'(err2_reg);
            d_prod3_reg <= hpid_pkg::PROD_W'(kd_reg) * hpid_pkg::PROD_W'(deriv2_reg);
        end
    end

    // stage 4: integrator update and proportional plus derivative sum
    assign integ_sum = hpid_pkg::SUM_W'(integ_reg) + hpid_pkg::SUM_W'(i_prod3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integ_reg <= '0;
        else if (ld4)
            integ_reg <= hpid_pkg::clamp_cmd(integ_sum, lo_reg, hi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            err4_reg    <= err3_reg;
            pd_sum4_reg <= hpid_pkg::SUM_W'(p_prod3_reg) + hpid_pkg::SUM_W'(d_prod3_reg);
        end
    end

    // stage 5: command sum and saturation into the output register
    assign cmd_sum = pd_sum4_reg + hpid_pkg::SUM_W'(integ_reg);

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            err5_reg <= err4_reg;
            cmd5_reg <= hpid_pkg::clamp_cmd(cmd_sum, lo_reg, hi_reg);
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {7'd0, err5_reg, cmd5_reg};

    // an empty output stage never holds back the input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !v5_reg |-> s_tready)
        else $error("input stalled with an empty output stage");

    // the returned error stays within one turn
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (err5_reg <= 17'sd36000 && err5_reg >= -17'sd36000))
        else $error("heading error outside one turn");

    // integrator stays within ordered limits after an update
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ld4) && !$past(cfg_valid) && lo_reg <= hi_reg)
        |-> (integ_reg >= lo_reg && integ_reg <= hi_reg))
        else $error("integrator outside command limits");

    // command stays within ordered limits when loaded
    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ld5) && !$past(cfg_valid) && lo_reg <= hi_reg)
        |-> (cmd5_reg >= lo_reg && cmd5_reg <= hi_reg))
        else $error("drive command outside command limits");

    // a stalled result is held in place
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !m_tready) |=> (v5_reg && $stable(cmd5_reg) && $stable(err5_reg)))
        else $error("stalled result changed");

endmodule

@@ test/heading_pid_with_angle_wrap_tb.sv @@
// Testbench for the heading PID block: directed table, then predictor-checked random streams
`timescale 1ns / 1ps

module heading_pid_with_angle_wrap_tb;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_SAMPLES   = 64;
    localparam int IDLE_SWAP_AT    = 170;
    localparam int IDLE_OFF_AT     = 340;
    localparam int HOLD_AT_RESULT  = 200;
    localparam int HOLD_CYCLES     = 60;
    localparam int TAIL_CYCLES     = 20;
    localparam int MAX_REPORTS     = 40;

    localparam logic [hpid_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam hpid_pkg::q16_t Q16_MAX = 32'sh7FFF_FFFF;
    localparam hpid_pkg::q16_t Q16_MIN = 32'sh8000_0000;
    localparam hpid_pkg::q16_t Q16_ONE = 32'sh0001_0000;

    // one row of the directed table; cmd and err only count where typed is set
    typedef struct packed {
        hpid_pkg::heading_t tgt;
        hpid_pkg::heading_t meas;
        logic               typed;
        hpid_pkg::q16_t     cmd;
        hpid_pkg::heading_t err;
    } sample_row_t;

    typedef struct packed {
        hpid_pkg::q16_t     cmd;
        hpid_pkg::heading_t err;
    } pid_result_t;

    localparam int DIRECTED_ROWS      = 22;
    localparam int FIRST_PID_ROW      = 13;
    localparam int FIRST_REVERSED_ROW = 19;

    // derivative-only gain of one and full-range limits for the typed rows
    localparam sample_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{17'sd100,    17'sd250,    1'b1, 32'sd16384000,  -17'sd150},
        '{17'sd0,      17'sd0,      1'b1, -32'sd16384000, 17'sd0},
        '{17'sd18000,  17'sd0,      1'b1, 32'sd0,         17'sd18000},
        '{17'sd18001,  17'sd0,      1'b1, 32'sd0,         -17'sd17999},
        '{-17'sd18001, 17'sd0,      1'b1, 32'sd0,         17'sd17999},
        '{-17'sd18000, 17'sd0,      1'b1, 32'sd0,         -17'sd18000},
        '{17'sd36000,  -17'sd36000, 1'b1, 32'h8000_0000,  17'sd36000},
        '{-17'sd36000, 17'sd36000,  1'b1, 32'h7FFF_FFFF,  -17'sd36000},
        '{17'sd65535,  17'h10000,   1'b1, 32'h8000_0000,  17'sd36000},
        '{17'h10000,   17'sd65535,  1'b1, 32'h7FFF_FFFF,  -17'sd36000},
        '{17'h10000,   17'sd0,      1'b1, 32'h8000_0000,  -17'sd29536},
        '{-17'sd40000, 17'sd0,      1'b1, 32'sd0,         -17'sd4000},
        '{17'sd50000,  17'sd0,      1'b1, 32'sd0,         17'sd14000},
        '{17'sd1000,   17'sd0,      1'b0, 32'sd0,         17'sd0},
        '{17'sd1000,   17'sd0,      1'b0, 32'sd0,         17'sd0},
        '{17'sd1000,   17'sd0,      1'b0, 32'sd0,         17'sd0},
        '{-17'sd1000,  17'sd0,      1'b0, 32'sd0,         17'sd0},
        '{-17'sd1000,  17'sd500,    1'b0, 32'sd0,         17'sd0},
        '{17'sd0,      -17'sd700,   1'b0, 32'sd0,         17'sd0},
        '{17'sd5000,   17'sd1000,   1'b0, 32'sd0,         17'sd0},
        '{-17'sd3000,  17'sd0,      1'b0, 32'sd0,         17'sd0},
        '{17'sd0,      17'sd0,      1'b0, 32'sd0,         17'sd0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [16:0] target_heading, [33:17] measured_heading
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;    // [31:0] drive_command, [48:32] heading_error

    // typed expectation travelling alongside the offered sample
    logic        offer_typed;
    pid_result_t offer_result;

    // controller copy: settings and state
    hpid_pkg::q16_t kp_gain    = '0;
    hpid_pkg::q16_t ki_gain    = '0;
    hpid_pkg::q16_t kd_gain    = '0;
    hpid_pkg::q16_t low_limit  = '0;
    hpid_pkg::q16_t high_limit = '0;
    longint integ_acc  = 0;
    longint last_meas  = 0;

    pid_result_t pending_results[$];
    int results_seen  = 0;
    int items_sent    = 0;
    int fail_count    = 0;
    int reports_shown = 0;
    int cycle_count   = 0;
    int tx_idle_pct   = 21;
    int rx_idle_pct   = 50;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    heading_pid_with_angle_wrap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // high limit tested first; reversed limits yield high above it and low at or below it
    function automatic longint saturate_command(input longint v);
        if (v > longint'(high_limit))
            return longint'(high_limit);
        if (v < longint'(low_limit))
            return longint'(low_limit);
        return v;
    endfunction

    // wrap the error into one turn, run the PID law and advance the state
    function automatic pid_result_t advance_controller(input hpid_pkg::heading_t tgt,
                                                       input hpid_pkg::heading_t meas);
        longint      diff;
        longint      meas_step;
        longint      drive;
        pid_result_t r;
        diff = longint'(tgt) - longint'(meas);
        if ((diff < 0 ? -diff : diff) > longint'(hpid_pkg::HALF_TURN))
            diff += longint'(hpid_pkg::FULL_TURN);
        if ((diff < 0 ? -diff : diff) > longint'(hpid_pkg::FULL_TURN))
            diff -= longint'(hpid_pkg::TWO_TURNS);
        // headings outside one turn can still leave the error out of range
        if (diff > longint'(hpid_pkg::FULL_TURN))
            diff = longint'(hpid_pkg::FULL_TURN);
        if (diff < -longint'(hpid_pkg::FULL_TURN))
            diff = -longint'(hpid_pkg::FULL_TURN);
        integ_acc = saturate_command(integ_acc + longint'(ki_gain) * diff);
        meas_step = longint'(meas) - last_meas;
        drive = longint'(kp_gain) * diff + integ_acc + longint'(kd_gain) * meas_step;
        drive = saturate_command(drive);
        last_meas = longint'(meas);
        r.cmd = hpid_pkg::q16_t'(drive);
        r.err = hpid_pkg::heading_t'(diff);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (reports_shown < MAX_REPORTS)
        begin
            reports_shown++;
            $display("mismatch at %0t ns: %s got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    function automatic hpid_pkg::q16_t moderate_gain();
        return hpid_pkg::q16_t'(int'($urandom_range(0, 262144)) - 131072);
    endfunction

    function automatic hpid_pkg::q16_t any_word();
        case ($urandom_range(4))
            0: return '0;
            1: return Q16_MAX;
            2: return Q16_MIN;
            3: return moderate_gain();
            default: return hpid_pkg::q16_t'($urandom);
        endcase
    endfunction

    // one register write transaction; valid stays up for back-to-back writes
    task automatic write_reg(input logic [hpid_pkg::CFG_IDX_W-1:0] idx,
                             input hpid_pkg::q16_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            hpid_pkg::CFG_KP:   kp_gain    = value;
            hpid_pkg::CFG_KI:   ki_gain    = value;
            hpid_pkg::CFG_KD:   kd_gain    = value;
            hpid_pkg::CFG_LOW:  low_limit  = value;
            hpid_pkg::CFG_HIGH: high_limit = value;
            default:  ;
        endcase
    endtask

    // pause the stream, drain the pipeline, then rewrite every register
    task automatic load_settings(input hpid_pkg::q16_t kp, input hpid_pkg::q16_t ki,
                                 input hpid_pkg::q16_t kd, input hpid_pkg::q16_t lo,
                                 input hpid_pkg::q16_t hi, input bit with_unused);
        s_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        if (with_unused)
            write_reg(CFG_UNUSED, hpid_pkg::q16_t'($urandom));
        write_reg(hpid_pkg::CFG_KP, kp);
        write_reg(hpid_pkg::CFG_KI, ki);
        write_reg(hpid_pkg::CFG_KD, kd);
        write_reg(hpid_pkg::CFG_LOW, lo);
        write_reg(hpid_pkg::CFG_HIGH, hi);
        cfg_valid <= 1'b0;
    endtask

    // offer one sample after an optional random gap; valid stays up on return
    task automatic send_sample(input hpid_pkg::heading_t tgt, input hpid_pkg::heading_t meas,
                               input logic typed, input pid_result_t expected);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= {6'b0, meas, tgt};
        offer_typed  <= typed;
        offer_result <= expected;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // result checking, sample prediction and receiver back-pressure
    always @(posedge clk)
    begin
        pid_result_t want;
        pid_result_t got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            // check the result transaction before predicting the new sample
            if (m_tvalid && m_tready)
            begin
                got.cmd = m_tdata[31:0];
                got.err = m_tdata[48:32];
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, drive_command", got.cmd, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.cmd !== want.cmd)
                        report_mismatch("drive_command", got.cmd, want.cmd);
                    if (got.err !== want.err)
                        report_mismatch("heading_error", got.err, want.err);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = advance_controller(s_tdata[16:0], s_tdata[33:17]);
                if (offer_typed)
                    want = offer_result;
                pending_results.push_back(want);
            end
            // one long hold-off lets the pipeline fill and stall the input
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // cycle limit
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus
    initial
    begin
        int                 row;
        int                 phase;
        int                 k;
        int                 idx;
        int                 kind;
        int                 offset;
        hpid_pkg::heading_t tgt;
        hpid_pkg::heading_t meas;
        hpid_pkg::q16_t     lo;

        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= hpid_pkg::CFG_KP;
        cfg_data     <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        offer_typed  <= 1'b0;
        offer_result <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: wrap cases first, then integrator wind-up, then reversed limits
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (row == 0)
                load_settings('0, '0, Q16_ONE, Q16_MIN, Q16_MAX, 1'b0);
            else if (row == FIRST_PID_ROW)
                load_settings(Q16_ONE, Q16_ONE, 32'shFFFF_8000, 32'shF830_0000,
                              32'sh07D0_0000, 1'b0);
            else if (row == FIRST_REVERSED_ROW)
                load_settings(32'sh100, 32'sh100, '0, 32'sh0001_0000, 32'shFFFF_0000, 1'b0);
            send_sample(DIRECTED[row].tgt, DIRECTED[row].meas, DIRECTED[row].typed,
                        '{DIRECTED[row].cmd, DIRECTED[row].err});
        end

        // random streams under a sequence of settings
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: load_settings(moderate_gain(), moderate_gain(), moderate_gain(),
                                 hpid_pkg::q16_t'(-int'($urandom_range(0, 32'h1000_0000))),
                                 hpid_pkg::q16_t'($urandom_range(0, 32'h1000_0000)), 1'b0);
                1: load_settings(Q16_MAX, Q16_MAX, Q16_MIN, Q16_MIN, Q16_MAX, 1'b0);
                2: load_settings(Q16_MIN, Q16_MIN, Q16_MAX, Q16_MIN, Q16_MAX, 1'b0);
                3: load_settings(moderate_gain(), moderate_gain(), moderate_gain(),
                                 hpid_pkg::q16_t'($urandom_range(1, 32'h0100_0000)),
                                 hpid_pkg::q16_t'(-int'($urandom_range(0, 32'h0100_0000))),
                                 1'b1);
                4:
                begin
                    lo = hpid_pkg::q16_t'($urandom);
                    load_settings(moderate_gain(), moderate_gain(), moderate_gain(), lo, lo, 1'b0);
                end
                default: load_settings(any_word(), any_word(), any_word(), any_word(),
                                       any_word(), 1'b0);
            endcase
            for (k = 0; k < PHASE_SAMPLES; k++)
            begin
                idx = phase * PHASE_SAMPLES + k;
                if (idx == IDLE_SWAP_AT)
                begin
                    tx_idle_pct = 50;
                    rx_idle_pct <= 21;
                end
                else if (idx == IDLE_OFF_AT)
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
                // mostly headings within one turn, some near the wrap points, some raw
                kind = $urandom_range(99);
                meas = hpid_pkg::heading_t'(int'($urandom_range(0, 72000)) - 36000);
                if (kind < 60)
                begin
                    tgt = hpid_pkg::heading_t'(int'($urandom_range(0, 72000)) - 36000);
                end
                else if (kind < 80)
                begin
                    offset = int'($urandom_range(0, 2)) - 1 + ($urandom_range(1) ? 18000 : 36000);
                    if ($urandom_range(1))
                        offset = -offset;
                    tgt = hpid_pkg::heading_t'(int'(meas) + offset);
                end
                else
                begin
                    tgt  = hpid_pkg::heading_t'($urandom);
                    meas = hpid_pkg::heading_t'($urandom);
                end
                send_sample(tgt, meas, 1'b0, '0);
            end
        end

        // drain and let any stray result show up
        s_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ heading_pid_with_angle_wrap.f @@
sv/hpid_pkg.sv
sv/hpid_err_wrap.sv
sv/heading_pid_with_angle_wrap.sv
test/heading_pid_with_angle_wrap_tb.sv
